/* hw/rtl/assert_macros.svh */
// Assertion macros used by the datapath of the suffix array search unit.
// Standalone header; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/saps_pkg.sv */
// Shared types and constants of the suffix array search unit.
// No dependencies; used by the controller, the datapath and the top level.
package saps_pkg;

  localparam int TEXT_DEPTH_DEF    = 4096;
  localparam int PATTERN_DEPTH_DEF = 64;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 12;
  localparam int VALUE_W  = 12;
  localparam int PLEN_W   = 7;
  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 12;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_TEXT    = 3'd0,
    ACT_LOAD_SUFFIX  = 3'd1,
    ACT_LOAD_PATTERN = 3'd2,
    ACT_QUERY        = 3'd3,
    ACT_FETCH        = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_SUF_WAIT,
    ST_BYTES,
    ST_FETCH_WAIT,
    ST_RES
  } state_e;

  typedef struct packed {
    logic wr_text;
    logic wr_suffix;
    logic wr_pattern;
    logic start_query;
    logic start_fetch;
    logic mid_issue;
    logic pos_load;
    logic byte_step;
    logic cmp_apply;
    logic phase_next;
    logic query_finish;
    logic fetch_finish;
    logic res_load;
    logic upper;       // second search: an equal suffix moves lo up
  } saps_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic query_empty;
    logic cmp_done;
    logic out_free;
  } saps_status_t;

endpackage

/* hw/rtl/saps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module saps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/saps_ctrl.sv */
// Sequencer of the suffix array search unit: decodes words and steps the searches.
// Depends on saps_pkg; drives saps_dp through a command struct.
module saps_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [saps_pkg::ACTION_W-1:0]  action_i,
  output logic                           in_ready_o,
  input  saps_pkg::saps_status_t         status_i,
  output saps_pkg::saps_cmd_t            cmd_o
);
  import saps_pkg::*;

  state_e state_q, state_d;
  logic   phase_q, phase_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    cmd_o.upper = phase_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          unique case (action_e'(action_i))
            ACT_LOAD_TEXT:    cmd_o.wr_text    = 1'b1;
            ACT_LOAD_SUFFIX:  cmd_o.wr_suffix  = 1'b1;
            ACT_LOAD_PATTERN: cmd_o.wr_pattern = 1'b1;
            ACT_QUERY: begin
              cmd_o.start_query = 1'b1;
              // empty text or pattern: skip straight to the finish path
              phase_d = status_i.query_empty;
              state_d = ST_MID;
            end
            ACT_FETCH: begin
              cmd_o.start_fetch = 1'b1;
              state_d = ST_FETCH_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_MID: begin
        if (status_i.lo_lt_hi) begin
          cmd_o.mid_issue = 1'b1;
          state_d = ST_SUF_WAIT;
        end else if (!phase_q) begin
          cmd_o.phase_next = 1'b1;
          phase_d = 1'b1;
        end else begin
          cmd_o.query_finish = 1'b1;
          state_d = ST_RES;
        end
      end
      ST_SUF_WAIT: begin
        cmd_o.pos_load = 1'b1;
        state_d = ST_BYTES;
      end
      ST_BYTES: begin
        if (status_i.cmp_done) begin
          cmd_o.cmp_apply = 1'b1;
          state_d = ST_MID;
        end else begin
          cmd_o.byte_step = 1'b1;
        end
      end
      ST_FETCH_WAIT: begin
        cmd_o.fetch_finish = 1'b1;
        state_d = ST_RES;
      end
      ST_RES: begin
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/saps_dp.sv */
// Datapath of the suffix array search unit: stores, search registers, output word.
// Depends on saps_pkg, saps_ram and assert_macros.svh; commanded by saps_ctrl.
`include "assert_macros.svh"

module saps_dp #(
  parameter int TEXT_DEPTH    = saps_pkg::TEXT_DEPTH_DEF,
  parameter int PATTERN_DEPTH = saps_pkg::PATTERN_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [saps_pkg::LEN_W-1:0]    cfg_wdata_i,
  input  logic [saps_pkg::INDEX_W-1:0]  index_i,
  input  logic [saps_pkg::VALUE_W-1:0]  value_i,
  input  logic [saps_pkg::PLEN_W-1:0]   plen_i,
  input  saps_pkg::saps_cmd_t           cmd_i,
  output saps_pkg::saps_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [saps_pkg::LEN_W-1:0]    out_first_o,
  output logic [saps_pkg::LEN_W-1:0]    out_count_o,
  output logic [saps_pkg::POS_W-1:0]    out_pos_o,
  output logic                          out_bad_o
);
  import saps_pkg::*;

  localparam int AW     = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PAW    = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int PSUM_W = ((POS_W > PLEN_W) ? POS_W : PLEN_W) + 1;

  // configuration and kept range
  logic [LEN_W-1:0]  text_length_q;
  logic [LEN_W-1:0]  range_start_q, range_count_q;

  // search registers
  logic [LEN_W-1:0]  n_q, lo_q, hi_q, mid_q, first_q;
  logic [PLEN_W-1:0] m_q, i_q;
  logic [POS_W-1:0]  pos_q;
  logic              rv_q;

  // result staging and output word
  logic              kind_q, bad_q, fetch_use_q;
  logic [POS_W-1:0]  fpos_q;
  logic              out_valid_q, out_kind_q, out_bad_q;
  logic [LEN_W-1:0]  out_first_q, out_count_q;
  logic [POS_W-1:0]  out_pos_q;

  logic [LEN_W-1:0]  n_in;
  logic [PLEN_W-1:0] m_in;
  logic [LEN_W:0]    mid_sum;
  logic [LEN_W-1:0]  mid_calc;
  logic [LEN_W:0]    fetch_rank;
  logic              fetch_ok, fetch_rank_ok;
  logic [PSUM_W-1:0] p_sum;
  logic              mismatch, past_text, all_done, cmp_lt, cmp_eq, go_right;

  logic [BYTE_W-1:0]  text_rdata, pat_rdata;
  logic [VALUE_W-1:0] suf_rdata;
  logic               text_we, suf_we, pat_we, suf_re;
  logic [AW-1:0]      suf_raddr;

  assign n_in = (32'(text_length_q) > TEXT_DEPTH) ? LEN_W'(TEXT_DEPTH) : text_length_q;
  assign m_in = (32'(plen_i) > PATTERN_DEPTH) ? PLEN_W'(PATTERN_DEPTH) : plen_i;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_calc = mid_sum[LEN_W:1];

  assign fetch_rank    = {1'b0, range_start_q} + (LEN_W + 1)'(index_i);
  assign fetch_ok      = LEN_W'(index_i) < range_count_q;
  assign fetch_rank_ok = 32'(fetch_rank) < TEXT_DEPTH;

  // byte compare: the pending read is checked before the next one is issued
  assign p_sum     = PSUM_W'(pos_q) + PSUM_W'(i_q);
  assign mismatch  = rv_q && (text_rdata != pat_rdata);
  assign all_done  = (i_q == m_q);
  assign past_text = 32'(p_sum) >= 32'(n_q);
  assign cmp_lt    = mismatch ? (text_rdata < pat_rdata) : (!all_done && past_text);
  assign cmp_eq    = !mismatch && all_done;
  assign go_right  = cmp_lt || (cmp_eq && cmd_i.upper);

  assign status_o.lo_lt_hi    = lo_q < hi_q;
  assign status_o.query_empty = (n_in == '0) || (m_in == '0);
  assign status_o.cmp_done    = mismatch || all_done || past_text;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  // stores
  assign text_we   = cmd_i.wr_text && (32'(index_i) < TEXT_DEPTH);
  assign suf_we    = cmd_i.wr_suffix && (32'(index_i) < TEXT_DEPTH);
  assign pat_we    = cmd_i.wr_pattern && (32'(index_i) < PATTERN_DEPTH);
  assign suf_re    = cmd_i.mid_issue || cmd_i.start_fetch;
  assign suf_raddr = cmd_i.start_fetch ? AW'(fetch_rank) : AW'(mid_calc);

  saps_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (AW'(index_i)),
    .wdata_i (value_i[BYTE_W-1:0]),
    .re_i    (cmd_i.byte_step),
    .raddr_i (AW'(p_sum)),
    .rdata_o (text_rdata)
  );

  saps_ram #(.WIDTH(VALUE_W), .DEPTH(TEXT_DEPTH)) u_suffix_ram (
    .clk_i   (clk_i),
    .we_i    (suf_we),
    .waddr_i (AW'(index_i)),
    .wdata_i (value_i),
    .re_i    (suf_re),
    .raddr_i (suf_raddr),
    .rdata_o (suf_rdata)
  );

  saps_ram #(.WIDTH(BYTE_W), .DEPTH(PATTERN_DEPTH)) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (PAW'(index_i)),
    .wdata_i (value_i[BYTE_W-1:0]),
    .re_i    (cmd_i.byte_step),
    .raddr_i (PAW'(i_q)),
    .rdata_o (pat_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_length_q <= '0;
      range_start_q <= '0;
      range_count_q <= '0;
      rv_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        text_length_q <= cfg_wdata_i;
      end
      if (cmd_i.query_finish) begin
        range_start_q <= first_q;
        range_count_q <= lo_q - first_q;
      end
      if (cmd_i.byte_step) begin
        rv_q <= 1'b1;
      end else if (cmd_i.pos_load || cmd_i.cmp_apply) begin
        rv_q <= 1'b0;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_query) begin
      n_q     <= n_in;
      m_q     <= m_in;
      lo_q    <= '0;
      first_q <= '0;
      hi_q    <= status_o.query_empty ? '0 : n_in;
    end
    if (cmd_i.mid_issue) begin
      mid_q <= mid_calc;
    end
    if (cmd_i.pos_load) begin
      pos_q <= suf_rdata;
      i_q   <= '0;
    end
    if (cmd_i.byte_step) begin
      i_q <= i_q + PLEN_W'(1);
    end
    if (cmd_i.cmp_apply) begin
      if (go_right) begin
        lo_q <= mid_q + LEN_W'(1);
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.phase_next) begin
      first_q <= lo_q;
      hi_q    <= n_q;
    end
    if (cmd_i.query_finish) begin
      kind_q <= KIND_QUERY;
      fpos_q <= '0;
      bad_q  <= 1'b0;
    end
    if (cmd_i.start_fetch) begin
      kind_q      <= KIND_FETCH;
      bad_q       <= !fetch_ok;
      fetch_use_q <= fetch_ok && fetch_rank_ok;
    end
    if (cmd_i.fetch_finish) begin
      fpos_q <= fetch_use_q ? suf_rdata : '0;
    end
    if (cmd_i.res_load) begin
      out_kind_q  <= kind_q;
      out_first_q <= range_start_q;
      out_count_q <= range_count_q;
      out_pos_q   <= fpos_q;
      out_bad_q   <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_first_o = out_first_q;
  assign out_count_o = out_count_q;
  assign out_pos_o   = out_pos_q;
  assign out_bad_o   = out_bad_q;

  `ASSERT_IMPLIES(a_mid_in_window, cmd_i.mid_issue, (lo_q < hi_q) && (hi_q <= n_q), "mid outside window")
  `ASSERT_IMPLIES(a_byte_in_pattern, cmd_i.byte_step, (i_q < m_q) && !past_text, "byte read out of range")
  `ASSERT_IMPLIES(a_upper_not_below, cmd_i.query_finish, lo_q >= first_q, "upper bound below lower bound")
  `ASSERT_IMPLIES(a_no_overwrite, cmd_i.res_load, !out_valid_q || out_ready_i, "output word overwritten")
  `ASSERT_ALWAYS(a_range_bound, 32'(range_start_q) + 32'(range_count_q) <= TEXT_DEPTH, "range past text")

endmodule

/* hw/rtl/suffix_array_pattern_search_unit.sv */
// Suffix array pattern search: top level joining the sequencer and the datapath.
// Depends on saps_pkg, saps_ctrl, saps_dp (which holds the saps_ram stores).
//
// Usage:
//   Input words on s_axis: tuser selects load text byte, load suffix entry,
//   load pattern byte, query or fetch. Loads write one store entry and give no
//   output word. A query binary searches the suffix array twice (lower and
//   upper bound) and returns the first rank and match count, which are kept.
//   A fetch returns the text position of the match at a given offset.
//   text_length is written on the cfg port while the unit is idle.
// Timing:
//   A load leaves the unit idle, so the next word can follow it directly. A fetch
//   reads the suffix store, stages the match position, then loads the output word;
//   the next word is taken once the unit is back in idle. A query runs two binary
//   searches of at most ceil(log2(n+1)) steps, each step comparing bytes until a
//   mismatch, the pattern end or the text end. The byte compare loop, one text and
//   one pattern byte read per cycle, sets most of a query's time. One word is
//   worked on at a time; s_axis_tready is high only when the unit is idle.
// Reset and stalls:
//   Reset clears text_length and the kept range; the stores hold garbage until
//   loaded. A stalled m_axis holds its word; loads are still taken, and a new
//   result waits inside until the output register frees.
module suffix_array_pattern_search_unit #(
  parameter int TEXT_DEPTH    = saps_pkg::TEXT_DEPTH_DEF,
  parameter int PATTERN_DEPTH = saps_pkg::PATTERN_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [saps_pkg::LEN_W-1:0]          cfg_wdata_i,  // text_length
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [saps_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // index, value, pattern_length
  input  logic [saps_pkg::ACTION_W-1:0]       s_axis_tuser,   // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [saps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // m_axis_tdata: first_rank, match_count, match_position, offset_invalid
  output logic                                m_axis_tuser    // result_kind
);
  import saps_pkg::*;

  localparam int VAL_LSB  = INDEX_W;
  localparam int PLEN_LSB = INDEX_W + VALUE_W;
  localparam int OUT_USED = 2 * LEN_W + POS_W + 1;

  saps_cmd_t         cmd;
  saps_status_t      status;
  logic              out_kind, out_bad;
  logic [LEN_W-1:0]  out_first, out_count;
  logic [POS_W-1:0]  out_pos;

  saps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  saps_dp #(
    .TEXT_DEPTH    (TEXT_DEPTH),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .index_i     (s_axis_tdata[INDEX_W-1:0]),
    .value_i     (s_axis_tdata[VAL_LSB +: VALUE_W]),
    .plen_i      (s_axis_tdata[PLEN_LSB +: PLEN_W]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_first_o (out_first),
    .out_count_o (out_count),
    .out_pos_o   (out_pos),
    .out_bad_o   (out_bad)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED){1'b0}}, out_bad, out_pos, out_count, out_first};

endmodule

/* dv/tb_suffix_array_pattern_search_unit.sv */
// Testbench for the suffix array pattern search unit: loads text, suffix and pattern
// stores, runs queries and fetches, and checks every output word against a predictor.
// Depends on saps_pkg and suffix_array_pattern_search_unit.
module tb_suffix_array_pattern_search_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import saps_pkg::*;

  localparam int TXT_D        = TEXT_DEPTH_DEF;
  localparam int PAT_D        = PATTERN_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 50;
  localparam int QUIET_LIMIT   = 20000;

  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] first_rank;
    logic [LEN_W-1:0] match_count;
    logic [POS_W-1:0] match_position;
    logic             offset_invalid;
  } search_answer_t;

  class search_scoreboard;
    logic [BYTE_W-1:0] text_mem [TXT_D];
    logic [POS_W-1:0]  suffix_mem [TXT_D];
    logic [BYTE_W-1:0] pat_mem [PAT_D];
    int unsigned       text_len;
    int unsigned       kept_start;
    int unsigned       kept_count;
    search_answer_t    pending_answers[$];
    int                errors;

    function new();
      text_len   = 0;
      kept_start = 0;
      kept_count = 0;
      errors     = 0;
    endfunction

    // -1: suffix below pattern, 0: suffix starts with pattern, 1: above
    function int order_at(int unsigned rank, int unsigned n, int unsigned m);
      int unsigned pos;
      pos = suffix_mem[rank];
      for (int unsigned i = 0; i < m; i++) begin
        if (pos + i >= n) return -1;
        if (text_mem[pos + i] != pat_mem[i])
          return (text_mem[pos + i] < pat_mem[i]) ? -1 : 1;
      end
      return 0;
    endfunction

    function void note_word(logic [ACTION_W-1:0] act, int unsigned idx, int unsigned val,
                            int unsigned plen);
      int unsigned    n, m, lo, hi, mid, first;
      search_answer_t ans;
      ans = '0;
      case (act)
        ACT_LOAD_TEXT:    text_mem[idx] = BYTE_W'(val);
        ACT_LOAD_SUFFIX:  suffix_mem[idx] = POS_W'(val);
        ACT_LOAD_PATTERN: if (idx < PAT_D) pat_mem[idx] = BYTE_W'(val);
        ACT_QUERY: begin
          n = (text_len > TXT_D) ? TXT_D : text_len;
          m = (plen > PAT_D) ? PAT_D : plen;
          first = 0;
          kept_count = 0;
          if (n != 0 && m != 0) begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (order_at(mid, n, m) < 0) lo = mid + 1;
              else hi = mid;
            end
            first = lo;
            hi = n;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (order_at(mid, n, m) <= 0) lo = mid + 1;
              else hi = mid;
            end
            kept_count = lo - first;
          end
          kept_start = first;
          ans.kind        = KIND_QUERY;
          ans.first_rank  = LEN_W'(kept_start);
          ans.match_count = LEN_W'(kept_count);
          pending_answers.push_back(ans);
        end
        ACT_FETCH: begin
          ans.kind           = KIND_FETCH;
          ans.first_rank     = LEN_W'(kept_start);
          ans.match_count    = LEN_W'(kept_count);
          ans.offset_invalid = 1'b1;
          if (idx < kept_count) begin
            ans.offset_invalid = 1'b0;
            if (kept_start + idx < TXT_D) ans.match_position = suffix_mem[kept_start + idx];
          end
          pending_answers.push_back(ans);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic kind, logic [OUT_DATA_W-1:0] data);
      search_answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0b data %h",
                 $time, kind, data);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      compare_field("result_kind", want.kind, kind);
      compare_field("first_rank", want.first_rank, data[LEN_W-1:0]);
      compare_field("match_count", want.match_count, data[2*LEN_W-1:LEN_W]);
      compare_field("match_position", want.match_position,
                    data[2*LEN_W+POS_W-1:2*LEN_W]);
      compare_field("offset_invalid", want.offset_invalid, data[2*LEN_W+POS_W]);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [LEN_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;  // index, value, pattern_length
  logic [ACTION_W-1:0]    s_axis_tuser = '0;  // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;  // first_rank, match_count, match_position, offset_invalid
  logic                   m_axis_tuser;  // result_kind

  search_scoreboard tracker;
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  int  sorted_pos [TXT_D];
  int  merge_buf [TXT_D];

  suffix_array_pattern_search_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output side: check accepted words, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tuser, m_axis_tdata);
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left    <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // returns with tvalid still high at the accepting edge
  task automatic send_word(logic [ACTION_W-1:0] act, int unsigned idx, int unsigned val,
                           int unsigned plen);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, PLEN_W'(plen), VALUE_W'(val), INDEX_W'(idx)};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_word(act, INDEX_W'(idx), VALUE_W'(val), PLEN_W'(plen));
  endtask

  task automatic load_pattern(int unsigned at, logic [BYTE_W-1:0] b);
    send_word(ACT_LOAD_PATTERN, at, {4'($urandom_range(0, 15)), b}, $urandom_range(0, 127));
  endtask

  task automatic set_text_length(int unsigned len);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LEN_W'(len);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.text_len = len;
  endtask

  function automatic bit suffix_before(int a, int b, int n);
    while (a < n && b < n) begin
      if (tracker.text_mem[a] != tracker.text_mem[b])
        return tracker.text_mem[a] < tracker.text_mem[b];
      a++;
      b++;
    end
    return a >= n;
  endfunction

  // bottom-up merge sort of suffix start positions over the loaded text
  function automatic void sort_suffixes(int n);
    int w, lo, mid, hi, i, j, k;
    for (i = 0; i < n; i++) sorted_pos[i] = i;
    for (w = 1; w < n; w *= 2) begin
      for (lo = 0; lo < n; lo += 2 * w) begin
        mid = (lo + w < n) ? lo + w : n;
        hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
        i = lo;
        j = mid;
        for (k = lo; k < hi; k++) begin
          if (j >= hi || (i < mid && !suffix_before(sorted_pos[j], sorted_pos[i], n))) begin
            merge_buf[k] = sorted_pos[i];
            i++;
          end else begin
            merge_buf[k] = sorted_pos[j];
            j++;
          end
        end
      end
      for (i = 0; i < n; i++) sorted_pos[i] = merge_buf[i];
    end
  endfunction

  // alph 0: alternating 00/FF, 256: any byte, else a small letter alphabet
  task automatic load_text_and_suffixes(int unsigned len, int unsigned alph, bit scramble);
    int unsigned       n, pos;
    logic [BYTE_W-1:0] b;
    n = (len > TXT_D) ? TXT_D : len;
    for (int unsigned i = 0; i < n; i++) begin
      if (alph == 0) b = i[0] ? 8'hFF : 8'h00;
      else if (alph >= 256) b = BYTE_W'($urandom_range(0, 255));
      else b = BYTE_W'(8'h61 + $urandom_range(0, alph - 1));
      send_word(ACT_LOAD_TEXT, i, {4'($urandom_range(0, 15)), b}, $urandom_range(0, 127));
    end
    sort_suffixes(n);
    for (int unsigned i = 0; i < n; i++) begin
      pos = sorted_pos[i];
      // an occasional entry pointing anywhere, often beyond the text
      if (scramble && $urandom_range(0, 63) == 0) pos = $urandom_range(0, 4095);
      send_word(ACT_LOAD_SUFFIX, i, pos, $urandom_range(0, 127));
    end
  endtask

  // pattern taken from the text, then a query and a few fetches on its range
  task automatic run_search(output int unsigned sent);
    int unsigned       n, p, m, plen, shots, off;
    logic [BYTE_W-1:0] b;
    n = (tracker.text_len > TXT_D) ? TXT_D : tracker.text_len;
    p = (n == 0) ? 0 : $urandom_range(0, n - 1);
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PAT_D) : $urandom_range(1, 6);
    for (int unsigned i = 0; i < m; i++) begin
      if (p + i < n && $urandom_range(0, 15) != 0) b = tracker.text_mem[p + i];
      else b = BYTE_W'($urandom_range(0, 255));
      load_pattern(i, b);
    end
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(m, 127) : m;
    send_word(ACT_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095), plen);
    shots = $urandom_range(0, 4);
    for (int unsigned s = 0; s < shots; s++) begin
      case ($urandom_range(0, 5))
        0: off = (tracker.kept_count > 4095) ? 4095 : tracker.kept_count;
        1: off = $urandom_range(0, 4095);
        default: off = (tracker.kept_count == 0) ? 0 : $urandom_range(0, tracker.kept_count - 1);
      endcase
      send_word(ACT_FETCH, off, $urandom_range(0, 4095), $urandom_range(0, 127));
    end
    sent = m + 1 + shots;
  endtask

  task automatic send_noise(output int unsigned counted);
    logic [ACTION_W-1:0] act;
    act = ACTION_W'($urandom_range(0, 2**ACTION_W - 1));
    send_word(act, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 127));
    counted = (act <= ACT_FETCH) ? 1 : 0;
  endtask

  task automatic run_phase(int unsigned len, int unsigned alph, int unsigned items,
                           int gp, int sp);
    int unsigned done, k;
    gap_pct   = gp;
    stall_pct = sp;
    set_text_length(len);
    load_text_and_suffixes(len, alph, 1'b1);
    done = 0;
    while (done < items) begin
      if ($urandom_range(0, 3) != 0) run_search(k);
      else send_noise(k);
      done += k;
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty text: kept range stays empty, fetches are all out of range
    gap_pct   = 20;
    stall_pct = 20;
    set_text_length(0);
    for (int unsigned i = 0; i < PAT_D; i++) load_pattern(i, BYTE_W'($urandom_range(0, 255)));
    send_word(ACT_FETCH, 0, 0, 0);
    send_word(ACT_QUERY, 0, 0, 0);
    send_word(ACT_QUERY, 4095, 4095, 127);
    send_word(ACT_FETCH, 4095, 4095, 127);
    for (int a = ACT_FETCH + 1; a < 2**ACTION_W; a++)
      send_word(ACTION_W'(a), 4095, 4095, 127);
    send_word(ACT_LOAD_PATTERN, PAT_D, 4095, 0);
    send_word(ACT_LOAD_PATTERN, 4095, 4095, 0);

    // one byte of text; a two byte pattern runs past the only suffix
    set_text_length(1);
    send_word(ACT_LOAD_TEXT, 0, 4095, 0);
    send_word(ACT_LOAD_SUFFIX, 0, 0, 0);
    load_pattern(0, 8'hFF);
    send_word(ACT_QUERY, 0, 0, 1);
    send_word(ACT_FETCH, 0, 0, 0);
    send_word(ACT_FETCH, 1, 0, 0);
    load_pattern(1, 8'h00);
    send_word(ACT_QUERY, 0, 0, 2);
    send_word(ACT_FETCH, 0, 0, 0);

    // 00 FF 00 FF 00 FF: three hits, then a suffix entry beyond the text
    set_text_length(6);
    load_text_and_suffixes(6, 0, 1'b0);
    load_pattern(0, 8'h00);
    load_pattern(1, 8'hFF);
    send_word(ACT_QUERY, 0, 0, 2);
    for (int unsigned i = 0; i < 4; i++) send_word(ACT_FETCH, i, 0, 0);
    send_word(ACT_LOAD_SUFFIX, 0, 4095, 0);
    send_word(ACT_QUERY, 0, 0, 2);
    send_word(ACT_QUERY, 0, 0, 64);
    send_word(ACT_QUERY, 0, 0, 127);

    run_phase(5, 2, 50, 30, 30);
    run_phase(37, 3, 50, 0, 20);
    run_phase(2, 2, 30, 20, 0);
    run_phase(90, 4, 50, 10, 40);
    run_phase(40, 256, 40, 40, 10);
    calm = 1'b1;
    run_phase(23, 3, 50, 0, 0);

    s_axis_tvalid <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
